// ===== design/assert_macros.svh =====
// Assertion macros used by the framer design file.
// Each macro samples on i_clk and is disabled while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== design/sdf7_pkg.sv =====
// Package for the sysex dump framer: frame constants, register indexes,
// microcode types and the microcode ROM. No dependencies.
package sdf7_pkg;

    localparam logic [7:0] SOX_BYTE  = 8'hF0;
    localparam logic [7:0] EOX_BYTE  = 8'hF7;
    localparam logic [7:0] CHAN_BASE = 8'h30;
    localparam logic [2:0] GROUP_LEN = 3'd7;
    localparam int         GROUP_DEPTH = int'(GROUP_LEN);

    localparam logic [3:0] CHANNEL_RST = 4'd0;
    localparam logic [6:0] MFR_ID_RST  = 7'd66;
    localparam logic [6:0] MODEL_RST   = 7'd88;
    localparam logic [6:0] FUNC_RST    = 7'd64;

    typedef enum logic [1:0] {
        CFG_CHANNEL = 2'd0,
        CFG_MFR_ID  = 2'd1,
        CFG_MODEL   = 2'd2,
        CFG_FUNC    = 2'd3
    } t_cfg_idx;

    // Sequencer step addresses
    typedef enum logic [3:0] {
        STEP_ACCEPT = 4'd0,
        STEP_SOX    = 4'd1,
        STEP_MFR    = 4'd2,
        STEP_CHAN   = 4'd3,
        STEP_MODEL  = 4'd4,
        STEP_FUNC   = 4'd5,
        STEP_LEAD   = 4'd6,
        STEP_DATA   = 4'd7,
        STEP_EOX    = 4'd8
    } t_step;

    // Output byte source
    typedef enum logic [3:0] {
        SRC_NONE,
        SRC_SOX,
        SRC_MFR,
        SRC_CHAN,
        SRC_MODEL,
        SRC_FUNC,
        SRC_LEAD,
        SRC_DATA,
        SRC_EOX
    } t_src;

    // Jump condition
    typedef enum logic [2:0] {
        JMP_DISPATCH,   // wait for input, branch on header/flush
        JMP_NEXT,       // fall through
        JMP_HDR_END,    // flush ? lead : accept
        JMP_DATA,       // loop over group, then eox or accept
        JMP_END         // back to accept
    } t_jmp;

    typedef struct packed {
        t_src src;
        t_jmp jmp;
    } t_uword;

    function automatic t_uword f_ucode(input t_step step);
        t_uword w;
        case (step)
            STEP_ACCEPT: w = '{src: SRC_NONE,  jmp: JMP_DISPATCH};
            STEP_SOX:    w = '{src: SRC_SOX,   jmp: JMP_NEXT};
            STEP_MFR:    w = '{src: SRC_MFR,   jmp: JMP_NEXT};
            STEP_CHAN:   w = '{src: SRC_CHAN,  jmp: JMP_NEXT};
            STEP_MODEL:  w = '{src: SRC_MODEL, jmp: JMP_NEXT};
            STEP_FUNC:   w = '{src: SRC_FUNC,  jmp: JMP_HDR_END};
            STEP_LEAD:   w = '{src: SRC_LEAD,  jmp: JMP_NEXT};
            STEP_DATA:   w = '{src: SRC_DATA,  jmp: JMP_DATA};
            STEP_EOX:    w = '{src: SRC_EOX,   jmp: JMP_END};
            default:     w = '{src: SRC_NONE,  jmp: JMP_END};
        endcase
        return w;
    endfunction

endpackage

// ===== design/sysex_dump_framer_7bit_pack.sv =====
// MIDI sysex dump framer with 7-to-8 bit packing, microcoded sequencer.
// Depends on sdf7_pkg (constants, microcode ROM) and assert_macros.svh.
//
// s_axis: payload bytes (tdata[7:0] = data_byte, tlast = final_byte).
// m_axis: sysex frame (tdata = out_byte, tlast = run_last on the last byte
//   caused by one input transaction, tuser = frame_end on the closing 0xF7).
// The first byte of a frame causes the 5-byte header (F0, manufacturer,
// 0x30|channel, model, function). Bytes collect in a 7-entry group; a full
// group or one closed by tlast goes out as a lead byte of top bits and the
// bytes with bit 7 cleared. tlast also adds the closing F7.
// Sequencing: the accept step, then one step per emitted byte; a flush of n
// bytes emits n+1 bytes, the header 5 and the closing F7 1. The ROM walk, one
// control word per cycle while m_axis_tready does not stall, sets the rate;
// s_axis_tready is high only in the accept step, so no byte is taken mid-run.
// The first output byte is registered in the step that follows the accept step.
// A stall on m_axis_tready holds the output register and freezes the
// sequencer on its current step; nothing is dropped.
// Reset (synchronous, i_rst_n low) returns to the accept step, empties the
// group, clears header state and restores register defaults.
// Config writes (i_cfg_we/idx/data) apply at once; issue them only while idle.
`include "assert_macros.svh"

module sysex_dump_framer_7bit_pack (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // configuration write port
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [6:0] i_cfg_data,
    // payload in
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
    input  logic       s_axis_tlast,   // final_byte
    // frame out
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic       m_axis_tlast,   // run_last
    output logic       m_axis_tuser    // [0] frame_end
);

    // config registers
    logic [3:0] r_channel;
    logic [6:0] r_mfr_id;
    logic [6:0] r_model;
    logic [6:0] r_func;

    // group store, payload only
    logic [7:0] r_store [sdf7_pkg::GROUP_DEPTH];

    // sequencer and datapath control
    sdf7_pkg::t_step r_pc,    n_pc;
    logic [2:0]      r_fill,  n_fill;   // bytes held in open group
    logic [2:0]      r_cnt,   n_cnt;    // bytes in group being flushed
    logic [2:0]      r_idx,   n_idx;    // data emit index
    logic            r_hdr,   n_hdr;    // header of open frame sent
    logic            r_fin,   n_fin;    // current transaction ends frame
    logic            r_flush, n_flush;  // current transaction flushes group
    logic            r_ovalid, n_ovalid;
    logic [7:0]      r_odata,  n_odata;
    logic            r_olast,  n_olast;
    logic            r_oend,   n_oend;

    sdf7_pkg::t_uword uw;
    logic             accept;
    logic             emit;
    logic [2:0]       cnt_new;
    logic             flush_new;
    logic [7:0]       lead;
    logic [7:0]       byte_sel;

    assign uw            = sdf7_pkg::f_ucode(r_pc);
    assign s_axis_tready = (r_pc == sdf7_pkg::STEP_ACCEPT);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign emit          = (uw.src != sdf7_pkg::SRC_NONE) && (!r_ovalid || m_axis_tready);
    assign cnt_new       = r_fill + 3'd1;
    assign flush_new     = (cnt_new == sdf7_pkg::GROUP_LEN) || s_axis_tlast;

    // lead byte: top bit of each held byte, bit 7 always clear
    always_comb begin
        lead = '0;
        for (int j = 0; j < sdf7_pkg::GROUP_DEPTH; j++) begin
            lead[j] = (3'(j) < r_cnt) && r_store[j][7];
        end
    end

    always_comb begin
        case (uw.src)
            sdf7_pkg::SRC_SOX:   byte_sel = sdf7_pkg::SOX_BYTE;
            sdf7_pkg::SRC_MFR:   byte_sel = {1'b0, r_mfr_id};
            sdf7_pkg::SRC_CHAN:  byte_sel = sdf7_pkg::CHAN_BASE | {4'd0, r_channel};
            sdf7_pkg::SRC_MODEL: byte_sel = {1'b0, r_model};
            sdf7_pkg::SRC_FUNC:  byte_sel = {1'b0, r_func};
            sdf7_pkg::SRC_LEAD:  byte_sel = lead;
            sdf7_pkg::SRC_DATA:  byte_sel = {1'b0, r_store[r_idx][6:0]};
            sdf7_pkg::SRC_EOX:   byte_sel = sdf7_pkg::EOX_BYTE;
            default:             byte_sel = '0;
        endcase
    end

    always_comb begin
        n_pc     = r_pc;
        n_fill   = r_fill;
        n_cnt    = r_cnt;
        n_idx    = r_idx;
        n_hdr    = r_hdr;
        n_fin    = r_fin;
        n_flush  = r_flush;
        n_ovalid = r_ovalid;
        n_odata  = r_odata;
        n_olast  = r_olast;
        n_oend   = r_oend;

        if (r_ovalid && m_axis_tready) begin
            n_ovalid = 1'b0;
        end

        case (uw.jmp)
            sdf7_pkg::JMP_DISPATCH: begin
                if (accept) begin
                    n_cnt   = cnt_new;
                    n_fin   = s_axis_tlast;
                    n_flush = flush_new;
                    n_fill  = flush_new ? 3'd0 : cnt_new;
                    n_hdr   = !s_axis_tlast;
                    if (!r_hdr) begin
                        n_pc = sdf7_pkg::STEP_SOX;
                    end else if (flush_new) begin
                        n_pc = sdf7_pkg::STEP_LEAD;
                    end
                end
            end
            sdf7_pkg::JMP_NEXT: begin
                if (emit) begin
                    n_pc = sdf7_pkg::t_step'(r_pc + 4'd1);
                end
            end
            sdf7_pkg::JMP_HDR_END: begin
                if (emit) begin
                    n_pc = r_flush ? sdf7_pkg::STEP_LEAD : sdf7_pkg::STEP_ACCEPT;
                end
            end
            sdf7_pkg::JMP_DATA: begin
                if (emit) begin
                    if (r_idx == r_cnt - 3'd1) begin
                        n_pc = r_fin ? sdf7_pkg::STEP_EOX : sdf7_pkg::STEP_ACCEPT;
                    end else begin
                        n_idx = r_idx + 3'd1;
                    end
                end
            end
            sdf7_pkg::JMP_END: begin
                if (emit || uw.src == sdf7_pkg::SRC_NONE) begin
                    n_pc = sdf7_pkg::STEP_ACCEPT;
                end
            end
            default: n_pc = sdf7_pkg::STEP_ACCEPT;
        endcase

        if (emit && uw.src == sdf7_pkg::SRC_LEAD) begin
            n_idx = 3'd0;
        end

        if (emit) begin
            n_ovalid = 1'b1;
            n_odata  = byte_sel;
            // last byte of a transaction's run: sequencer returns to accept
            n_olast  = (n_pc == sdf7_pkg::STEP_ACCEPT);
            n_oend   = (uw.src == sdf7_pkg::SRC_EOX);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc      <= sdf7_pkg::STEP_ACCEPT;
            r_fill    <= '0;
            r_cnt     <= '0;
            r_idx     <= '0;
            r_hdr     <= 1'b0;
            r_fin     <= 1'b0;
            r_flush   <= 1'b0;
            r_ovalid  <= 1'b0;
            r_channel <= sdf7_pkg::CHANNEL_RST;
            r_mfr_id  <= sdf7_pkg::MFR_ID_RST;
            r_model   <= sdf7_pkg::MODEL_RST;
            r_func    <= sdf7_pkg::FUNC_RST;
        end else begin
            r_pc     <= n_pc;
            r_fill   <= n_fill;
            r_cnt    <= n_cnt;
            r_idx    <= n_idx;
            r_hdr    <= n_hdr;
            r_fin    <= n_fin;
            r_flush  <= n_flush;
            r_ovalid <= n_ovalid;
            if (i_cfg_we) begin
                case (sdf7_pkg::t_cfg_idx'(i_cfg_idx))
                    sdf7_pkg::CFG_CHANNEL: r_channel <= i_cfg_data[3:0];
                    sdf7_pkg::CFG_MFR_ID:  r_mfr_id  <= i_cfg_data;
                    sdf7_pkg::CFG_MODEL:   r_model   <= i_cfg_data;
                    sdf7_pkg::CFG_FUNC:    r_func    <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        r_odata <= n_odata;
        r_olast <= n_olast;
        r_oend  <= n_oend;
        if (accept) begin
            r_store[r_fill] <= s_axis_tdata;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tlast  = r_olast;
    assign m_axis_tuser  = r_oend;

    // closing F7 always ends the run of its transaction
    `ASSERT_IMPL(a_eox_is_last, r_ovalid && r_oend, r_olast)
    // group never holds a full group between transactions
    `ASSERT_IMPL(a_fill_bound, 1'b1, r_fill < sdf7_pkg::GROUP_LEN)
    // a frame's first byte starts the header sequence
    `ASSERT_NEXT(a_hdr_start, accept && !r_hdr, r_pc == sdf7_pkg::STEP_SOX)
    // a byte that closes nothing leaves the sequencer ready for the next one
    `ASSERT_NEXT(a_no_flush_idle, accept && r_hdr && !flush_new, r_pc == sdf7_pkg::STEP_ACCEPT)

endmodule
